/* hw/rtl/tcst_pkg.sv */
// ----------------------------------------------------------------------------
// Touch contact slot table package
// Shared types, operation codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tcst_pkg;

    localparam int DEFAULT_SLOTS = 16;

    localparam logic [2:0] OP_DOWN   = 3'd0;
    localparam logic [2:0] OP_MOTION = 3'd1;
    localparam logic [2:0] OP_UP     = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [2:0] CFG_RENDER_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_RENDER_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_OFFSET_X      = 3'd2;
    localparam logic [2:0] CFG_OFFSET_Y      = 3'd3;
    localparam logic [2:0] CFG_SCALE_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_SCALE_HEIGHT  = 3'd5;
    localparam logic [2:0] CFG_IGNORED_DEV   = 3'd6;

    localparam logic [13:0] RST_RENDER_WIDTH  = 14'd640;
    localparam logic [13:0] RST_RENDER_HEIGHT = 14'd480;
    localparam logic [15:0] RST_SCALE         = 16'd256;
    localparam logic [31:0] RST_IGNORED_DEV   = 32'hFFFF_FFFF;

    localparam logic [31:0] RELEASED_ID = 32'hFFFF_FFFF;
    localparam logic [15:0] POS_MAX     = 16'h7FFF;
    localparam logic [15:0] POS_MIN     = 16'h8000;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] device_id;
        logic signed [31:0] finger_id;
        logic [15:0]        norm_x;
        logic [15:0]        norm_y;
        logic [15:0]        norm_pressure;
        logic [3:0]         read_index;
    } tcst_req_t;

    typedef struct packed {
        logic               hit;
        logic [3:0]         slot_index;
        logic [15:0]        active_mask;
        logic               slot_active;
        logic signed [31:0] slot_finger;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        pressure;
    } tcst_res_t;

    typedef struct packed {
        logic [31:0] device;
        logic [31:0] finger;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] pressure;
    } tcst_entry_t;

endpackage

/* hw/rtl/tcst_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/touch_contact_slot_table.sv */
// ----------------------------------------------------------------------------
// Touch contact slot table
// Finger-down, motion, up, cancel and read requests on a table of contacts.
// Ignored, unknown or out-of-range read requests reply without the table; reads fetch
// the slot directly; other requests scan the table one slot a cycle, then finger-down and
// motion map x and y through one shared 16-step divider.
// Busy stays high while any request is in progress.
// Reset clears the table at once through per-slot valid bits; no sweep.
// Results carry a one-cycle done strobe and cannot be stalled.
// ----------------------------------------------------------------------------
module touch_contact_slot_table
    import tcst_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tcst_req_t   req,
    output logic        done,
    output tcst_res_t   res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int MASK_N = (SLOTS < 16) ? SLOTS : 16;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_MUL, S_PRE, S_DIV, S_END, S_WRITE, S_FINAL, S_REPLY
    } state_t;

    state_t state_reg, state_next;
    logic found_reg, found_next;
    logic free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic [SLOT_W-1:0] sel_reg, sel_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic axis_reg, axis_next;
    logic [3:0] step_reg, step_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic done_reg, done_next;
    tcst_res_t res_reg, res_next;

    logic [13:0] render_width_reg, render_height_reg;
    logic [15:0] offset_x_reg, offset_y_reg;
    logic [15:0] scale_width_reg, scale_height_reg;
    logic [31:0] ignored_dev_reg;

    tcst_req_t req_reg, req_next;
    tcst_entry_t hold_reg, hold_next;
    logic signed [33:0] num_reg, num_next;
    logic [31:0] rem_reg, rem_next;
    logic [39:0] dv_reg, dv_next;
    logic [15:0] quo_reg, quo_next;
    logic neg_reg, neg_next;
    logic zero_reg, zero_next;
    logic ovf_reg, ovf_next;
    logic [15:0] mx_reg, mx_next;
    logic [15:0] my_reg, my_next;

    logic ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    tcst_entry_t ram_wdata, ram_rdata, cur;

    logic [15:0] m_norm, m_scale;
    logic [13:0] m_size;
    logic [15:0] m_off;
    logic [29:0] m_prod;
    logic [31:0] m_mag;
    logic [23:0] m_div;
    logic ge;
    logic [15:0] pos_calc;
    logic act;
    logic ignored;

    tcst_ram #(
        .WIDTH ($bits(tcst_entry_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur     = valid_reg[rd_idx_reg] ? ram_rdata : '0;
    assign act     = active_reg[cmp_idx_reg];
    assign ignored = (req.op <= OP_CANCEL) && (req.device_id == ignored_dev_reg);

    always_comb
    begin
        m_norm  = axis_reg ? req_reg.norm_y : req_reg.norm_x;
        m_size  = axis_reg ? render_height_reg : render_width_reg;
        m_off   = axis_reg ? offset_y_reg : offset_x_reg;
        m_scale = axis_reg ? scale_height_reg : scale_width_reg;
        m_prod  = {14'd0, m_norm} * {16'd0, m_size};
        m_mag   = num_reg[33] ? 32'(-num_reg) : num_reg[31:0];
        m_div   = {m_scale, 8'd0};
        ge      = {8'd0, rem_reg} >= dv_reg;
        if (zero_reg)
        begin
            pos_calc = '0;
        end
        else if (neg_reg)
        begin
            pos_calc = (ovf_reg || quo_reg > POS_MIN) ? POS_MIN : 16'(16'd0 - quo_reg);
        end
        else
        begin
            pos_calc = (ovf_reg || quo_reg > POS_MAX) ? POS_MAX : quo_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        sel_next        = sel_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        axis_next       = axis_reg;
        step_next       = step_reg;
        active_next     = active_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        req_next        = req_reg;
        hold_next       = hold_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        dv_next         = dv_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;
        ovf_next        = ovf_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        ram_we          = 1'b0;
        ram_waddr       = sel_reg;
        ram_wdata       = '0;
        ram_raddr       = sel_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next        = req;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    axis_next       = 1'b0;
                    if (ignored || req.op > OP_READ)
                    begin
                        state_next = S_REPLY;
                    end
                    else if (req.op == OP_READ)
                    begin
                        if (int'(req.read_index) < SLOTS)
                        begin
                            found_next = 1'b1;
                            sel_next   = SLOT_W'(req.read_index);
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            state_next = S_REPLY;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                ram_raddr = scan_cnt_reg[SLOT_W-1:0];
                if (scan_cnt_reg < CNT_W'(SLOTS))
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[SLOT_W-1:0];
                end
                if (cmp_vld_reg)
                begin
                    case (req_reg.op)
                        OP_DOWN:
                        begin
                            if (cur.finger == req_reg.finger_id)
                            begin
                                found_next = 1'b1;
                                sel_next   = cmp_idx_reg;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                if (!act && !free_found_reg)
                                begin
                                    free_found_next = 1'b1;
                                    free_idx_next   = cmp_idx_reg;
                                end
                                if (cmp_idx_reg == LAST_SLOT)
                                begin
                                    if (free_found_reg || !act)
                                    begin
                                        found_next = 1'b1;
                                        sel_next   = free_found_reg ? free_idx_reg : cmp_idx_reg;
                                        state_next = S_MUL;
                                    end
                                    else
                                    begin
                                        state_next = S_REPLY;
                                    end
                                end
                            end
                        end
                        OP_MOTION, OP_UP:
                        begin
                            if (act && cur.finger == req_reg.finger_id)
                            begin
                                found_next = 1'b1;
                                sel_next   = cmp_idx_reg;
                                hold_next  = cur;
                                state_next = (req_reg.op == OP_UP) ? S_WRITE : S_MUL;
                            end
                            else if (cmp_idx_reg == LAST_SLOT)
                            begin
                                state_next = S_REPLY;
                            end
                        end
                        default:
                        begin
                            if (cur.device == req_reg.device_id)
                            begin
                                ram_we                   = 1'b1;
                                ram_waddr                = cmp_idx_reg;
                                ram_wdata                = cur;
                                ram_wdata.device         = RELEASED_ID;
                                ram_wdata.finger         = RELEASED_ID;
                                ram_wdata.pressure       = '0;
                                valid_next[cmp_idx_reg]  = 1'b1;
                                active_next[cmp_idx_reg] = 1'b0;
                                if (!found_reg)
                                begin
                                    found_next = 1'b1;
                                    sel_next   = cmp_idx_reg;
                                end
                            end
                            if (cmp_idx_reg == LAST_SLOT)
                            begin
                                state_next = (found_next) ? S_FINAL : S_REPLY;
                            end
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                num_next   = $signed({4'd0, m_prod}) - $signed({{2{m_off[15]}}, m_off, 16'd0});
                state_next = S_PRE;
            end

            S_PRE:
            begin
                neg_next  = num_reg[33];
                zero_next = (m_mag == '0);
                ovf_next  = ({8'd0, m_mag} >= {m_div, 16'd0});
                rem_next  = m_mag;
                dv_next   = {1'b0, m_div, 15'd0};
                quo_next  = '0;
                step_next = '0;
                state_next = (m_mag == '0 || {8'd0, m_mag} >= {m_div, 16'd0}) ? S_END : S_DIV;
            end

            S_DIV:
            begin
                rem_next  = ge ? rem_reg - dv_reg[31:0] : rem_reg;
                quo_next  = {quo_reg[14:0], ge};
                dv_next   = dv_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15)
                begin
                    state_next = S_END;
                end
            end

            S_END:
            begin
                if (axis_reg)
                begin
                    my_next    = pos_calc;
                    state_next = S_WRITE;
                end
                else
                begin
                    mx_next    = pos_calc;
                    axis_next  = 1'b1;
                    state_next = S_MUL;
                end
            end

            S_WRITE:
            begin
                ram_we              = 1'b1;
                ram_waddr           = sel_reg;
                valid_next[sel_reg] = 1'b1;
                case (req_reg.op)
                    OP_DOWN:
                    begin
                        ram_wdata            = {req_reg.device_id, req_reg.finger_id,
                                                mx_reg, my_reg, req_reg.norm_pressure};
                        active_next[sel_reg] = 1'b1;
                    end
                    OP_MOTION:
                    begin
                        ram_wdata = {hold_reg.device, hold_reg.finger,
                                     mx_reg, my_reg, req_reg.norm_pressure};
                    end
                    default:
                    begin
                        ram_wdata            = {RELEASED_ID, RELEASED_ID,
                                                hold_reg.x, hold_reg.y, 16'd0};
                        active_next[sel_reg] = 1'b0;
                    end
                endcase
                state_next = S_FINAL;
            end

            S_FINAL:
            begin
                ram_raddr  = sel_reg;
                state_next = S_REPLY;
            end

            S_REPLY:
            begin
                res_next             = '0;
                res_next.active_mask = 16'(active_reg[MASK_N-1:0]);
                if (found_reg)
                begin
                    res_next.hit         = 1'b1;
                    res_next.slot_index  = 4'(sel_reg);
                    res_next.slot_active = active_reg[sel_reg];
                    res_next.slot_finger = cur.finger;
                    res_next.pos_x       = cur.x;
                    res_next.pos_y       = cur.y;
                    res_next.pressure    = cur.pressure;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            found_reg         <= 1'b0;
            free_found_reg    <= 1'b0;
            free_idx_reg      <= '0;
            sel_reg           <= '0;
            scan_cnt_reg      <= '0;
            cmp_vld_reg       <= 1'b0;
            cmp_idx_reg       <= '0;
            rd_idx_reg        <= '0;
            axis_reg          <= 1'b0;
            step_reg          <= '0;
            active_reg        <= '0;
            valid_reg         <= '0;
            done_reg          <= 1'b0;
            res_reg           <= '0;
            render_width_reg  <= RST_RENDER_WIDTH;
            render_height_reg <= RST_RENDER_HEIGHT;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            scale_width_reg   <= RST_SCALE;
            scale_height_reg  <= RST_SCALE;
            ignored_dev_reg   <= RST_IGNORED_DEV;
        end
        else
        begin
            state_reg      <= state_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            sel_reg        <= sel_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            rd_idx_reg     <= ram_raddr;
            axis_reg       <= axis_next;
            step_reg       <= step_next;
            active_reg     <= active_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            res_reg        <= res_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RENDER_WIDTH:  render_width_reg  <= cfg_data[13:0];
                    CFG_RENDER_HEIGHT: render_height_reg <= cfg_data[13:0];
                    CFG_OFFSET_X:      offset_x_reg      <= cfg_data[15:0];
                    CFG_OFFSET_Y:      offset_y_reg      <= cfg_data[15:0];
                    CFG_SCALE_WIDTH:   scale_width_reg   <= cfg_data[15:0];
                    CFG_SCALE_HEIGHT:  scale_height_reg  <= cfg_data[15:0];
                    CFG_IGNORED_DEV:   ignored_dev_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        hold_reg <= hold_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        ovf_reg  <= ovf_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule
